FILE: rtl/sqe_pkg.sv
// sqe_pkg: shared types and constants for the streaming quantile estimator.
// No dependencies.
`default_nettype none
package sqe_pkg;
    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS = 17;
    localparam int OUT_BITS = 32;
    localparam int WIDE_BITS = 64;
    localparam logic [FRAC_BITS-1:0] FRAC_RESET = 17'd32768;
    localparam logic [FRAC_BITS-1:0] FRAC_ONE = 17'd65536;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic signed [SAMPLE_BITS-1:0] height_t;
    typedef logic [COUNT_BITS-1:0] pos_t;
    typedef logic [WIDE_BITS-1:0] wide_t;

    typedef struct packed {
        logic  mode;
        height_t sample;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] estimate;
        logic [OUT_BITS-1:0] sample_count;
        logic primed;
        logic count_saturated;
    } out_word_t;

    typedef struct packed {
        logic start;
        wide_t hi;
        wide_t lo;
        wide_t den;
    } div_req_t;

    typedef struct packed {
        logic done;
        wide_t quo;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/sqe_if.sv
// sqe_if: valid/ready stream channel.
// The payload type is a parameter that defaults to logic; no dependencies.
`default_nettype none
interface sqe_if #(parameter type word_t = logic);
    logic valid;
    logic ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/sqe_div.sv
// sqe_div: shared restoring divider, one quotient bit per cycle,
// floor({hi,lo}/den) saturating, zero for a zero den; depends on sqe_pkg.
`default_nettype none
module sqe_div (
    input wire logic clk,
    input wire logic rst_n,
    input wire sqe_pkg::div_req_t req,
    output sqe_pkg::div_rsp_t rsp
);
    import sqe_pkg::*;
    wide_t r_reg, r_next, lo_reg, lo_next, q_reg, q_next, den_reg, den_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    wide_t rs;
    logic carry;

    always_comb
    begin
        r_next = r_reg; lo_next = lo_reg; q_next = q_reg; den_next = den_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        carry = r_reg[WIDE_BITS-1];
        rs = {r_reg[WIDE_BITS-2:0], lo_reg[WIDE_BITS-1]};
        if (req.start)
        begin
            den_next = req.den;
            if (req.den == '0)
            begin
                q_next = '0; done_next = 1'b1;
            end
            else if (req.hi >= req.den)
            begin
                q_next = '1; done_next = 1'b1;
            end
            else
            begin
                r_next = req.hi; lo_next = req.lo; q_next = '0;
                cnt_next = 7'(WIDE_BITS); busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            lo_next = {lo_reg[WIDE_BITS-2:0], 1'b0};
            if (carry || rs >= den_reg)
            begin
                r_next = rs - den_reg; q_next = {q_reg[WIDE_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = rs; q_next = {q_reg[WIDE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next; lo_reg <= lo_next; q_reg <= q_next; den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo = q_reg;
endmodule
`default_nettype wire

FILE: rtl/sqe_mul.sv
// sqe_mul: 64x64 -> 128 multiplier built from one 32x32 partial product
// per cycle; depends on sqe_pkg.
`default_nettype none
module sqe_mul (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire sqe_pkg::wide_t a,
    input wire sqe_pkg::wide_t b,
    output logic done,
    output sqe_pkg::wide_t hi,
    output sqe_pkg::wide_t lo
);
    import sqe_pkg::*;
    localparam int H = WIDE_BITS / 2;
    wide_t a_reg, b_reg;
    logic [2*WIDE_BITS-1:0] acc_reg;
    logic [1:0] idx_reg;
    logic run_reg, done_reg;
    logic [H-1:0] pa, pb;
    wide_t pp;

    always_comb
    begin
        pa = idx_reg[0] ? a_reg[WIDE_BITS-1:H] : a_reg[H-1:0];
        pb = idx_reg[1] ? b_reg[WIDE_BITS-1:H] : b_reg[H-1:0];
    end
    assign pp = WIDE_BITS'(pa) * WIDE_BITS'(pb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0; done_reg <= 1'b0; idx_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1; idx_reg <= '0;
            end
            else if (run_reg)
            begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    run_reg <= 1'b0; done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a; b_reg <= b; acc_reg <= '0;
        end
        else if (run_reg)
            acc_reg <= acc_reg + ((2*WIDE_BITS)'(pp)
                       << (H * (32'(idx_reg[0]) + 32'(idx_reg[1]))));
    end

    assign done = done_reg;
    assign hi = acc_reg[2*WIDE_BITS-1:WIDE_BITS];
    assign lo = acc_reg[WIDE_BITS-1:0];
endmodule
`default_nettype wire

FILE: rtl/streaming_quantile_estimator.sv
// Streaming five-marker P-square quantile estimator, top level.
// Depends on sqe_pkg, sqe_if, sqe_mul and sqe_div.
// One word is taken at a time. A clear or a warm-up sample goes from acceptance
// through the output state, the fifth sample through five sort passes and then
// the output state. A later sample goes through a locate step, then markers 1 to
// 3 in turn, each through a desired-position and a test step when it stays and
// also two products on the shared multiplier and four divisions on the shared
// divider when it moves, then the output state. A new word is taken while the
// last result waits; the output state holds until that result is taken. Writing
// the cfg channel clears the estimator; values above 65536 are taken as 65536.
`default_nettype none
module streaming_quantile_estimator (
    input wire logic clk,
    input wire logic rst_n,
    sqe_if.sink in_ch,
    sqe_if.source out_ch,
    sqe_if.sink cfg
);
    import sqe_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_LOCATE= 12'b000000000010,
        S_SORT  = 12'b000000000100,
        S_DES   = 12'b000000001000,
        S_TEST  = 12'b000000010000,
        S_MUL   = 12'b000000100000,
        S_MWAIT = 12'b000001000000,
        S_DIV   = 12'b000010000000,
        S_DWAIT = 12'b000100000000,
        S_CORR  = 12'b001000000000,
        S_APPLY = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t st_reg;
    height_t h_reg [5];
    pos_t p_reg [5];
    pos_t cnt_reg;
    logic [FRAC_BITS-1:0] q_reg;
    height_t v_reg;
    logic [1:0] mi_reg;
    logic [2:0] si_reg;
    logic [1:0] op_reg;
    logic fwd_reg;
    wide_t t1_reg, corr_reg;
    logic [COUNT_BITS+FRAC_BITS-1:0] prod_reg;
    wide_t fl_reg;
    logic nz_reg;
    logic sat_reg;
    out_word_t ow_reg;
    logic ov_reg;

    // adjust operands
    logic [2:0] ci;
    wide_t n, bgap, egap, up, down;
    always_comb
    begin
        ci = {1'b0, mi_reg};
        n = WIDE_BITS'(p_reg[ci]);
        bgap = WIDE_BITS'(p_reg[ci+3'd1] - p_reg[ci]);
        egap = WIDE_BITS'(p_reg[ci] - p_reg[ci-3'd1]);
        up = WIDE_BITS'($signed(h_reg[ci+3'd1])) - WIDE_BITS'($signed(h_reg[ci]));
        down = WIDE_BITS'($signed(h_reg[ci])) - WIDE_BITS'($signed(h_reg[ci-3'd1]));
    end

    // cell search, first match from the bottom
    logic lt0, lt1, lt2, lt3;
    always_comb
    begin
        lt0 = v_reg < h_reg[0];
        lt1 = lt0 || (v_reg < h_reg[1]);
        lt2 = lt1 || (v_reg < h_reg[2]);
        lt3 = lt2 || (v_reg < h_reg[3]);
    end

    // shared units
    logic m_start, m_done;
    wide_t m_a, m_b, m_hi, m_lo;
    sqe_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b), .done(m_done),
                   .hi(m_hi), .lo(m_lo));
    div_req_t dreq;
    div_rsp_t drsp;
    sqe_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

    wide_t mhi_reg, mlo_reg, den_reg;

    always_comb
    begin
        m_start = (st_reg == S_MUL);
        m_a = (op_reg == 2'd0) ? up : down;
        if (op_reg == 2'd0)
            m_b = fwd_reg ? egap + 64'd1 : egap - 64'd1;
        else
            m_b = fwd_reg ? bgap - 64'd1 : bgap + 64'd1;
        dreq.start = (st_reg == S_DIV);
        dreq.hi = mhi_reg;
        dreq.lo = mlo_reg;
        dreq.den = den_reg;
    end

    // desired position per marker
    wide_t fl_c, low_c;
    logic nz_c;
    always_comb
    begin
        low_c = WIDE_BITS'(prod_reg[16:0]) + (WIDE_BITS'(cnt_reg[0]) << 16);
        unique case (mi_reg)
            2'd1:
            begin
                fl_c = WIDE_BITS'(prod_reg >> 17); nz_c = prod_reg[16:0] != '0;
            end
            2'd2:
            begin
                fl_c = WIDE_BITS'(prod_reg >> 16); nz_c = prod_reg[15:0] != '0;
            end
            default:
            begin
                fl_c = WIDE_BITS'(cnt_reg >> 1) + WIDE_BITS'(prod_reg >> 17) + (low_c >> 17);
                nz_c = low_c[16:0] != '0;
            end
        endcase
    end

    logic cand_f, cand_b;
    assign cand_f = (fl_reg >= n + 64'd1) && (bgap > 64'd1);
    assign cand_b = (n >= 64'd1) && (fl_reg + WIDE_BITS'(nz_reg) <= n - 64'd1) && (egap > 64'd1);

    wide_t ssum;
    logic sovf;
    assign {sovf, ssum} = {1'b0, t1_reg} + {1'b0, drsp.quo};

    logic use_par;
    wide_t step;
    always_comb
    begin
        if (fwd_reg)
            use_par = (corr_reg < up) && (corr_reg != '0 || down != '0);
        else
            use_par = (corr_reg < down) && (corr_reg != '0 || up != '0);
        step = use_par ? corr_reg : drsp.quo;
    end

    assign in_ch.ready = (st_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (st_reg == S_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data = ow_reg;

    in_word_t iw;
    assign iw = in_ch.data;
    logic [FRAC_BITS-1:0] cfg_p;
    assign cfg_p = (cfg.data > FRAC_ONE) ? FRAC_ONE : cfg.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ov_reg <= 1'b0; q_reg <= FRAC_RESET; cnt_reg <= '0;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= '0; p_reg[i] <= '0;
            end
            mi_reg <= 2'd1; si_reg <= '0; op_reg <= '0; fwd_reg <= 1'b0;
            v_reg <= '0; t1_reg <= '0; corr_reg <= '0; prod_reg <= '0;
            fl_reg <= '0; nz_reg <= 1'b0; sat_reg <= 1'b0; ow_reg <= '0;
            mhi_reg <= '0; mlo_reg <= '0; den_reg <= '0;
        end
        else
        begin
            if (out_ch.ready && st_reg != S_OUT)
                ov_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                q_reg <= cfg_p; cnt_reg <= '0;
                for (int i = 0; i < 5; i++)
                begin
                    h_reg[i] <= '0; p_reg[i] <= '0;
                end
            end
            unique case (st_reg)
                S_IDLE:
                    if (in_ch.valid && in_ch.ready)
                    begin
                        v_reg <= iw.sample;
                        if (iw.mode)
                        begin
                            sat_reg <= 1'b0;
                            cnt_reg <= '0;
                            for (int i = 0; i < 5; i++)
                            begin
                                h_reg[i] <= '0; p_reg[i] <= '0;
                            end
                            st_reg <= S_OUT;
                        end
                        else if (cnt_reg == COUNT_MAX)
                        begin
                            sat_reg <= 1'b1; st_reg <= S_OUT;
                        end
                        else if (cnt_reg < COUNT_BITS'(5))
                        begin
                            sat_reg <= 1'b0;
                            h_reg[cnt_reg[2:0]] <= iw.sample;
                            cnt_reg <= cnt_reg + COUNT_BITS'(1);
                            if (cnt_reg == COUNT_BITS'(4))
                            begin
                                si_reg <= 3'd0; st_reg <= S_SORT;
                            end
                            else
                                st_reg <= S_OUT;
                        end
                        else
                        begin
                            sat_reg <= 1'b0; st_reg <= S_LOCATE;
                        end
                    end
                S_SORT:
                begin
                    // odd-even transposition, 5 passes
                    if (si_reg[0] == 1'b0)
                    begin
                        if (h_reg[0] > h_reg[1]) begin h_reg[0] <= h_reg[1]; h_reg[1] <= h_reg[0]; end
                        if (h_reg[2] > h_reg[3]) begin h_reg[2] <= h_reg[3]; h_reg[3] <= h_reg[2]; end
                    end
                    else
                    begin
                        if (h_reg[1] > h_reg[2]) begin h_reg[1] <= h_reg[2]; h_reg[2] <= h_reg[1]; end
                        if (h_reg[3] > h_reg[4]) begin h_reg[3] <= h_reg[4]; h_reg[4] <= h_reg[3]; end
                    end
                    si_reg <= si_reg + 3'd1;
                    if (si_reg == 3'd4)
                    begin
                        for (int i = 0; i < 5; i++)
                            p_reg[i] <= COUNT_BITS'(i);
                        st_reg <= S_OUT;
                    end
                end
                S_LOCATE:
                begin
                    if (lt0)
                        h_reg[0] <= v_reg;
                    if (!lt3 && v_reg >= h_reg[4])
                        h_reg[4] <= v_reg;
                    if (lt1) p_reg[1] <= p_reg[1] + COUNT_BITS'(1);
                    if (lt2) p_reg[2] <= p_reg[2] + COUNT_BITS'(1);
                    if (lt3) p_reg[3] <= p_reg[3] + COUNT_BITS'(1);
                    p_reg[4] <= p_reg[4] + COUNT_BITS'(1);
                    prod_reg <= (COUNT_BITS+FRAC_BITS)'(cnt_reg) * (COUNT_BITS+FRAC_BITS)'(q_reg);
                    mi_reg <= 2'd1;
                    st_reg <= S_DES;
                end
                S_DES:
                begin
                    fl_reg <= fl_c; nz_reg <= nz_c; st_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (cand_f || cand_b)
                    begin
                        fwd_reg <= cand_f; op_reg <= 2'd0; st_reg <= S_MUL;
                    end
                    else if (mi_reg == 2'd3)
                    begin
                        cnt_reg <= cnt_reg + COUNT_BITS'(1); st_reg <= S_OUT;
                    end
                    else
                    begin
                        mi_reg <= mi_reg + 2'd1; st_reg <= S_DES;
                    end
                end
                S_MUL:
                    st_reg <= S_MWAIT;
                S_MWAIT:
                    if (m_done)
                    begin
                        mhi_reg <= m_hi; mlo_reg <= m_lo;
                        den_reg <= (op_reg == 2'd0) ? bgap : egap;
                        st_reg <= S_DIV;
                    end
                S_DIV:
                    st_reg <= S_DWAIT;
                S_DWAIT:
                    if (drsp.done)
                    begin
                        unique case (op_reg)
                            2'd0:
                            begin
                                t1_reg <= drsp.quo; op_reg <= 2'd1; st_reg <= S_MUL;
                            end
                            2'd1:
                            begin
                                mhi_reg <= '0;
                                mlo_reg <= sovf ? '1 : ssum;
                                den_reg <= bgap + egap;
                                op_reg <= 2'd2; st_reg <= S_DIV;
                            end
                            2'd2:
                            begin
                                corr_reg <= drsp.quo;
                                mhi_reg <= '0;
                                mlo_reg <= fwd_reg ? up : down;
                                den_reg <= fwd_reg ? bgap : egap;
                                op_reg <= 2'd3; st_reg <= S_DIV;
                            end
                            default:
                                st_reg <= S_APPLY;
                        endcase
                    end
                S_APPLY:
                begin
                    if (fwd_reg)
                    begin
                        h_reg[ci] <= height_t'(WIDE_BITS'($signed(h_reg[ci])) + step);
                        p_reg[ci] <= p_reg[ci] + COUNT_BITS'(1);
                    end
                    else
                    begin
                        h_reg[ci] <= height_t'(WIDE_BITS'($signed(h_reg[ci])) - step);
                        p_reg[ci] <= p_reg[ci] - COUNT_BITS'(1);
                    end
                    if (mi_reg == 2'd3)
                    begin
                        cnt_reg <= cnt_reg + COUNT_BITS'(1); st_reg <= S_OUT;
                    end
                    else
                    begin
                        mi_reg <= mi_reg + 2'd1; st_reg <= S_DES;
                    end
                end
                S_OUT:
                    if (!ov_reg || out_ch.ready)
                    begin
                        ow_reg.estimate <= h_reg[2][OUT_BITS-1:0];
                        ow_reg.sample_count <= cnt_reg[OUT_BITS-1:0];
                        ow_reg.primed <= cnt_reg >= COUNT_BITS'(5);
                        ow_reg.count_saturated <= sat_reg;
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
